### rtl/core/md5_pkg.sv
`timescale 1ns / 1ps
package md5_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hEFCDAB89;
  localparam logic [31:0] InitC = 32'h98BADCFE;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam int          QueueDepth = 4;

  // item passed from front to back
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } md5_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5_result_t;

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    begin
      case (r)
        6'd0: k = 32'hD76AA478; 6'd1: k = 32'hE8C7B756; 6'd2: k = 32'h242070DB;
        6'd3: k = 32'hC1BDCEEE; 6'd4: k = 32'hF57C0FAF; 6'd5: k = 32'h4787C62A;
        6'd6: k = 32'hA8304613; 6'd7: k = 32'hFD469501; 6'd8: k = 32'h698098D8;
        6'd9: k = 32'h8B44F7AF; 6'd10: k = 32'hFFFF5BB1; 6'd11: k = 32'h895CD7BE;
        6'd12: k = 32'h6B901122; 6'd13: k = 32'hFD987193; 6'd14: k = 32'hA679438E;
        6'd15: k = 32'h49B40821; 6'd16: k = 32'hF61E2562; 6'd17: k = 32'hC040B340;
        6'd18: k = 32'h265E5A51; 6'd19: k = 32'hE9B6C7AA; 6'd20: k = 32'hD62F105D;
        6'd21: k = 32'h02441453; 6'd22: k = 32'hD8A1E681; 6'd23: k = 32'hE7D3FBC8;
        6'd24: k = 32'h21E1CDE6; 6'd25: k = 32'hC33707D6; 6'd26: k = 32'hF4D50D87;
        6'd27: k = 32'h455A14ED; 6'd28: k = 32'hA9E3E905; 6'd29: k = 32'hFCEFA3F8;
        6'd30: k = 32'h676F02D9; 6'd31: k = 32'h8D2A4C8A; 6'd32: k = 32'hFFFA3942;
        6'd33: k = 32'h8771F681; 6'd34: k = 32'h6D9D6122; 6'd35: k = 32'hFDE5380C;
        6'd36: k = 32'hA4BEEA44; 6'd37: k = 32'h4BDECFA9; 6'd38: k = 32'hF6BB4B60;
        6'd39: k = 32'hBEBFBC70; 6'd40: k = 32'h289B7EC6; 6'd41: k = 32'hEAA127FA;
        6'd42: k = 32'hD4EF3085; 6'd43: k = 32'h04881D05; 6'd44: k = 32'hD9D4D039;
        6'd45: k = 32'hE6DB99E5; 6'd46: k = 32'h1FA27CF8; 6'd47: k = 32'hC4AC5665;
        6'd48: k = 32'hF4292244; 6'd49: k = 32'h432AFF97; 6'd50: k = 32'hAB9423A7;
        6'd51: k = 32'hFC93A039; 6'd52: k = 32'h655B59C3; 6'd53: k = 32'h8F0CCC92;
        6'd54: k = 32'hFFEFF47D; 6'd55: k = 32'h85845DD1; 6'd56: k = 32'h6FA87E4F;
        6'd57: k = 32'hFE2CE6E0; 6'd58: k = 32'hA3014314; 6'd59: k = 32'h4E0811A1;
        6'd60: k = 32'hF7537E82; 6'd61: k = 32'hBD3AF235; 6'd62: k = 32'h2AD7D2BB;
        default: k = 32'hEB86D391;
      endcase
      return k;
    end
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] s);
    logic [4:0] n;
    begin
      case (s)
        4'd0: n = 5'd7;   4'd1: n = 5'd12;  4'd2: n = 5'd17;  4'd3: n = 5'd22;
        4'd4: n = 5'd5;   4'd5: n = 5'd9;   4'd6: n = 5'd14;  4'd7: n = 5'd20;
        4'd8: n = 5'd4;   4'd9: n = 5'd11;  4'd10: n = 5'd16; 4'd11: n = 5'd23;
        4'd12: n = 5'd6;  4'd13: n = 5'd10; 4'd14: n = 5'd15; default: n = 5'd21;
      endcase
      return n;
    end
  endfunction

endpackage

### rtl/core/md5_if.sv
`timescale 1ns / 1ps
interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [1:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### rtl/core/md5_front.sv
`timescale 1ns / 1ps
module md5_front (
  input  logic              clk,
  input  logic              rst,
  md5_in_if.sink            in_ch,
  output md5_pkg::md5_item_t q_item,
  output logic              q_valid,
  input  logic              q_pop
);
  import md5_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  md5_item_t          mem [QueueDepth];
  logic [PtrW-1:0]    wr_ptr;
  logic [PtrW-1:0]    rd_ptr;
  logic [PtrW:0]      count;
  logic               push;

  // drop items that carry nothing
  assign in_ch.ready = (count != (PtrW+1)'(QueueDepth));
  assign push = in_ch.valid && in_ch.ready && (in_ch.byte_present || in_ch.end_of_message);
  assign q_valid = (count != '0);
  assign q_item = mem[rd_ptr];

  // item queue
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{data_byte: in_ch.data_byte, byte_present: in_ch.byte_present,
                       end_of_message: in_ch.end_of_message};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
    end
  end
endmodule

### rtl/core/md5_back.sv
`timescale 1ns / 1ps
module md5_back (
  input  logic               clk,
  input  logic               rst,
  input  md5_pkg::md5_item_t q_item,
  input  logic               q_valid,
  output logic               q_pop,
  md5_out_if.source          out_ch
);
  import md5_pkg::*;

  typedef enum logic [2:0] {S_TAKE, S_ROUND, S_PAD, S_EMIT} state_t;

  state_t      state;
  logic [31:0] blk [16];
  logic [31:0] h [4];
  logic [31:0] a, b, c, d;
  logic [5:0]  rnd;
  logic [63:0] byte_count;
  logic        closing;
  logic        len_pending;
  logic        mark_pending;
  logic        len_blk;
  logic [5:0]  pad_pos;
  logic [1:0]  emit_idx;
  logic [3:0]  k;
  logic [31:0] f, w, sum, rot;
  logic [5:0]  fill_pos;
  logic [5:0]  close_pos;
  logic [63:0] bits;

  // message word, mixing function and rotated sum for this round
  always_comb begin
    case (rnd[5:4])
      2'd0: begin f = d ^ (b & (c ^ d)); k = rnd[3:0]; end
      2'd1: begin f = c ^ (d & (b ^ c)); k = 4'(rnd * 3'd5 + 6'd1); end
      2'd2: begin f = b ^ c ^ d;         k = 4'(rnd * 2'd3 + 6'd5); end
      default: begin f = c ^ (b | ~d);   k = 4'(rnd * 3'd7); end
    endcase
    w = blk[k];
    sum = a + f + round_const(rnd) + w;
    rot = (sum << rot_amount({rnd[5:4], rnd[1:0]}))
        | (sum >> (6'd32 - {1'b0, rot_amount({rnd[5:4], rnd[1:0]})}));
  end

  assign q_pop = (state == S_TAKE) && q_valid;
  assign fill_pos = byte_count[5:0];
  assign close_pos = q_item.byte_present ? fill_pos + 6'd1 : fill_pos;
  assign bits = {byte_count[60:0], 3'b000};

  // sequencer: take, compress, pad, emit
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_TAKE;
      h[0] <= InitA; h[1] <= InitB; h[2] <= InitC; h[3] <= InitD;
      byte_count <= '0;
      out_ch.valid <= 1'b0;
      closing <= 1'b0;
      len_pending <= 1'b0;
      mark_pending <= 1'b0;
      len_blk <= 1'b0;
      rnd <= '0;
      emit_idx <= '0;
      pad_pos <= '0;
    end else begin
      case (state)
        S_TAKE: begin
          if (q_valid) begin
            closing <= q_item.end_of_message;
            if (q_item.byte_present) begin
              blk[fill_pos[5:2]][8*fill_pos[1:0] +: 8] <= q_item.data_byte;
              byte_count <= byte_count + 64'd1;
            end
            if (q_item.byte_present && fill_pos == 6'd63) begin
              state <= S_ROUND;
              rnd <= '0;
              a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3];
              mark_pending <= 1'b1;
              len_pending <= 1'b1;
            end else if (q_item.end_of_message) begin
              state <= S_PAD;
              pad_pos <= close_pos;
              len_blk <= (close_pos < 6'd56);
              mark_pending <= 1'b1;
              len_pending <= 1'b1;
            end
          end
        end
        S_ROUND: begin
          a <= d; d <= c; c <= b;
          b <= b + rot;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            h[0] <= h[0] + d;
            h[1] <= h[1] + b + rot;
            h[2] <= h[2] + b;
            h[3] <= h[3] + c;
            if (closing && !len_pending) begin
              state <= S_EMIT;
              emit_idx <= '0;
            end else if (closing) begin
              state <= S_PAD;
              pad_pos <= '0;
              len_blk <= 1'b1;
            end else begin
              state <= S_TAKE;
            end
          end
        end
        S_PAD: begin
          // one byte per cycle: marker, zeros, then the length when this block carries it
          if (mark_pending && pad_pos == byte_count[5:0]) begin
            blk[pad_pos[5:2]][8*pad_pos[1:0] +: 8] <= PadByte;
            mark_pending <= 1'b0;
          end else if (len_blk && pad_pos >= 6'd56) begin
            blk[pad_pos[5:2]][8*pad_pos[1:0] +: 8] <= bits[8*pad_pos[2:0] +: 8];
          end else begin
            blk[pad_pos[5:2]][8*pad_pos[1:0] +: 8] <= 8'h00;
          end
          pad_pos <= pad_pos + 6'd1;
          if (pad_pos == 6'd63) begin
            state <= S_ROUND;
            rnd <= '0;
            a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3];
            // a marker past byte 55 leaves the length for a second block
            if (len_blk) len_pending <= 1'b0;
          end
        end
        S_EMIT: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            out_ch.digest_word <= h[emit_idx];
            out_ch.word_index <= emit_idx;
            out_ch.last_word <= (emit_idx == 2'd3);
            emit_idx <= emit_idx + 2'd1;
            if (emit_idx == 2'd3) begin
              state <= S_TAKE;
              closing <= 1'b0;
              h[0] <= InitA; h[1] <= InitB; h[2] <= InitC; h[3] <= InitD;
              byte_count <= '0;
            end
          end
        end
        default: state <= S_TAKE;
      endcase
      if (state != S_EMIT && out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
    end
  end
endmodule

### rtl/core/md5_message_digest_unit.sv
`timescale 1ns / 1ps
// md5 engine: four-item queue in front of a one-round-per-cycle compressor
// an item is registered in the queue, then popped by the take step when the sequencer is in it
// a byte that fills a block starts the rounds, and no further item is taken until they end
// closing pads one byte per cycle from the fill position to byte 63, then runs the rounds;
// a marker past byte 55 adds a second padded block and its rounds, then 4 words
// synchronous reset loads the initial chain words and empties the queue
module md5_message_digest_unit (
  input logic       clk,
  input logic       rst,
  md5_in_if.sink    in_ch,
  md5_out_if.source out_ch
);
  import md5_pkg::*;

  md5_item_t q_item;
  logic      q_valid;
  logic      q_pop;

  md5_front u_front (.clk, .rst, .in_ch, .q_item, .q_valid, .q_pop);
  md5_back  u_back  (.clk, .rst, .q_item, .q_valid, .q_pop, .out_ch);
endmodule

### verif/md5_tb_pkg.sv
`timescale 1ns / 1ps
package md5_tb_pkg;
  import md5_pkg::*;

  // bit-exact md5 digest predictor with its own running state
  class md5_scoreboard;
    logic [31:0] chain[4];
    logic [63:0] msg_len;
    logic [7:0]  blk[64];
    md5_result_t pending_words[$];
    int          mismatches;
    int          words_checked;
    int          messages;

    function new();
      mismatches = 0;
      words_checked = 0;
      messages = 0;
      restart();
    endfunction

    function void restart();
      chain[0] = InitA;
      chain[1] = InitB;
      chain[2] = InitC;
      chain[3] = InitD;
      msg_len = '0;
    endfunction

    function logic [31:0] rotl(logic [31:0] x, int n);
      logic [63:0] t;
      t = {x, x} << n;
      return t[63:32];
    endfunction

    function void compress();
      logic [31:0] w[16];
      logic [31:0] a, b, c, d, f, hold;
      int k, stage;
      for (int r = 0; r < 16; r++)
        w[r] = {blk[4*r+3], blk[4*r+2], blk[4*r+1], blk[4*r]};
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      for (int r = 0; r < 64; r++) begin
        stage = r / 16;
        case (stage)
          0: begin
            f = d ^ (b & (c ^ d));
            k = r % 16;
          end
          1: begin
            f = c ^ (d & (b ^ c));
            k = (5 * r + 1) % 16;
          end
          2: begin
            f = b ^ c ^ d;
            k = (3 * r + 5) % 16;
          end
          default: begin
            f = c ^ (b | ~d);
            k = (7 * r) % 16;
          end
        endcase
        hold = d;
        d = c;
        c = b;
        b = b + rotl(a + f + round_const(6'(r)) + w[k], rot_amount(4'(stage * 4 + r % 4)));
        a = hold;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
    endfunction

    // note one accepted input item
    function void note_item(md5_item_t it);
      int pos;
      logic [63:0] bits;
      md5_result_t res;
      if (it.byte_present) begin
        blk[msg_len[5:0]] = it.data_byte;
        msg_len++;
        if (msg_len[5:0] == 0) compress();
      end
      if (!it.end_of_message) return;
      pos = msg_len[5:0];
      bits = msg_len << 3;
      blk[pos] = PadByte;
      for (int i = pos + 1; i < 64; i++) blk[i] = 8'h00;
      if (pos >= 56) begin
        compress();
        for (int i = 0; i < 56; i++) blk[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) blk[56+i] = bits[8*i +: 8];
      compress();
      for (int i = 0; i < 4; i++) begin
        res.digest_word = chain[i];
        res.word_index = 2'(i);
        res.last_word = (i == 3);
        pending_words.push_back(res);
      end
      messages++;
      restart();
    endfunction

    // check one accepted digest word against the oldest expectation
    function void check_word(md5_result_t got, realtime t);
      md5_result_t exp;
      words_checked++;
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected digest word %h idx %0d last %0b", t,
                 got.digest_word, got.word_index, got.last_word);
        mismatches++;
        return;
      end
      exp = pending_words.pop_front();
      if (got.digest_word !== exp.digest_word) begin
        $display("%0t: digest_word expected %h actual %h", t, exp.digest_word,
                 got.digest_word);
        mismatches++;
      end
      if (got.word_index !== exp.word_index) begin
        $display("%0t: word_index expected %0d actual %0d", t, exp.word_index,
                 got.word_index);
        mismatches++;
      end
      if (got.last_word !== exp.last_word) begin
        $display("%0t: last_word expected %0b actual %0b", t, exp.last_word,
                 got.last_word);
        mismatches++;
      end
    endfunction
  endclass
endpackage

### verif/md5_message_digest_unit_test.sv
`timescale 1ns / 1ps
module md5_message_digest_unit_test;
  import md5_pkg::*;
  import md5_tb_pkg::*;

  logic clk;
  logic rst;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   items_sent;
  md5_scoreboard digest_sb;

  md5_in_if  in_ch();
  md5_out_if out_ch();

  md5_message_digest_unit u_top (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #60ms;
    $display("timeout");
    $display("FAIL");
    $finish;
  end

  // receiver: random stalls, check each accepted word
  initial begin
    md5_result_t got;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got.digest_word = out_ch.digest_word;
        got.word_index = out_ch.word_index;
        got.last_word = out_ch.last_word;
        digest_sb.check_word(got, $realtime);
      end
      out_ch.ready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // send one item, with random idle cycles before it
  task automatic send_item(logic [7:0] data, logic present, logic close);
    md5_item_t it;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.byte_present <= present;
    in_ch.end_of_message <= close;
    do @(posedge clk); while (!in_ch.ready);
    it.data_byte = data;
    it.byte_present = present;
    it.end_of_message = close;
    digest_sb.note_item(it);
    items_sent++;
  endtask

  // message of len bytes, optional absent-byte noise, close on the last byte or apart
  task automatic send_message(int len, bit close_apart);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (!close_apart && i == len - 1));
    end
    if (close_apart || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (digest_sb.pending_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    digest_sb = new();
    items_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.byte_present = 1'b0;
    in_ch.end_of_message = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty message, extreme bytes, ignored byte, padding edges
    send_item(8'hFF, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'hA5, 1'b1, 1'b0);
    send_item(8'h5A, 1'b0, 1'b1);
    drain();
    send_message(55, 1'b0);
    send_message(56, 1'b1);
    send_message(63, 1'b0);
    send_message(64, 1'b0);
    drain();

    // random messages, three idling phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 24 : (ph == 1) ? 52 : 0;
      recv_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 24 : 0;
      for (int m = 0; m < 6; m++) begin
        send_message(($urandom_range(7) == 0) ? $urandom_range(130) : $urandom_range(6),
                     $urandom_range(1));
        if (m == 2) drain();
      end
    end
    drain();
    repeat (200) @(posedge clk);

    $display("sent %0d items in %0d messages, checked %0d digest words",
             items_sent, digest_sb.messages, digest_sb.words_checked);
    $display("covered empty, short, pad-boundary and multi-block messages under stalls");
    if (digest_sb.mismatches == 0 && digest_sb.pending_words.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

### files.f
rtl/core/md5_pkg.sv
rtl/core/md5_if.sv
rtl/core/md5_front.sv
rtl/core/md5_back.sv
rtl/core/md5_message_digest_unit.sv
verif/md5_tb_pkg.sv
verif/md5_message_digest_unit_test.sv
